// File: sv/assert_macros.svh
// Assertion helpers for the lens point mapper checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held
`define LDPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition in this cycle implies consequence in the next one
`define LDPM_ASSERT_NEXT(label, cond, consq, msg) \
    `LDPM_ASSERT(label, (cond) |=> (consq), msg)

`endif

// File: sv/ldpm_pkg.sv
`default_nettype none
package ldpm_pkg;

    // Internal Q.30 values are signed 63 bit, bounded by 2^62 - 1
    localparam int unsigned QW = 63;
    typedef logic signed [QW-1:0] q_t;

    // Value with its sticky saturation flag
    typedef struct packed {
        logic f;
        q_t   v;
    } fq_t;

    typedef struct packed {
        logic               f;
        logic signed [23:0] v;
    } pix_t;

    localparam int unsigned FQ_W        = $bits(fq_t);
    localparam int unsigned MUL_LATENCY = 4;
    localparam int unsigned PIPE_DEPTH  = 43;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam q_t QBOUND                  = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [63:0] QBOUND64 = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam q_t ONE_Q30                 = 63'sd1073741824;

    localparam logic [63:0] FOCAL_RESET     = 64'h0001_0000_0001_0000;
    localparam logic [63:0] INV_FOCAL_RESET = 64'h4000_0000_4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL,
        REG_INV_FOCAL,
        REG_CENTER,
        REG_SKEW,
        REG_K1,
        REG_K2,
        REG_TANGENTIAL,
        REG_K5
    } cfg_reg_t;

    function automatic q_t zext32(logic [31:0] a);
        return q_t'({31'b0, a});
    endfunction

    function automatic q_t sext32(logic [31:0] a);
        return q_t'({{31{a[31]}}, a});
    endfunction

    // Saturating add, flags merged
    function automatic fq_t fq_add(fq_t a, fq_t b);
        logic signed [63:0] s;
        fq_t                r;
        s   = $signed({a.v[QW-1], a.v}) + $signed({b.v[QW-1], b.v});
        r.f = a.f | b.f;
        if (s > QBOUND64) begin
            r.f = 1'b1;
            r.v = QBOUND;
        end else if (s < -QBOUND64) begin
            r.f = 1'b1;
            r.v = -QBOUND;
        end else begin
            r.v = s[QW-1:0];
        end
        return r;
    endfunction

    function automatic fq_t fq_neg(fq_t a);
        fq_t r;
        r.f = a.f;
        r.v = -a.v;
        return r;
    endfunction

    // Round Q.16 to Q.8 (nearest, ties away) and clamp to 24 bits
    function automatic pix_t out_round(fq_t a);
        logic [QW-1:0]      mag;
        logic [QW-1:0]      sum;
        logic signed [55:0] sv;
        pix_t               r;
        mag = a.v[QW-1] ? QW'(-a.v) : QW'(a.v);
        sum = mag + QW'(128);
        sv  = a.v[QW-1] ? -$signed({1'b0, sum[QW-1:8]}) : $signed({1'b0, sum[QW-1:8]});
        r.f = a.f;
        if (sv > 56'sd8388607) begin
            r.f = 1'b1;
            r.v = 24'sh7F_FFFF;
        end else if (sv < -56'sd8388608) begin
            r.f = 1'b1;
            r.v = 24'sh80_0000;
        end else begin
            r.v = sv[23:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/ldpm_delay.sv
`default_nettype none
module ldpm_delay #(
    parameter int unsigned WIDTH = ldpm_pkg::FQ_W,
    parameter int unsigned DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift the line when the pipeline advances
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule
`default_nettype wire

// File: sv/ldpm_mulq.sv
`default_nettype none
module ldpm_mulq #(
    parameter int unsigned SHIFT = 30
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [62:0]   a_i,
    input  logic signed [62:0]   b_i,
    input  logic                 f_i,
    output ldpm_pkg::fq_t        y_o
);
    import ldpm_pkg::*;

    localparam int unsigned PW = 126;

    logic [62:0]   s1_ma_reg, s1_mb_reg;
    logic          s1_neg_reg, s1_f_reg;
    logic [63:0]   s2_p00_reg;
    logic [62:0]   s2_p01_reg, s2_p10_reg;
    logic [61:0]   s2_p11_reg;
    logic          s2_neg_reg, s2_f_reg;
    logic [PW-1:0] s3_prod_reg;
    logic          s3_neg_reg, s3_f_reg;
    fq_t           y_reg;
    logic [PW-1:0] rnd;
    logic          sat;
    logic [61:0]   mag;

    // Round and saturate the full product
    always_comb begin
        rnd = s3_prod_reg + (PW'(1) << (SHIFT - 1));
        sat = |rnd[PW-1:62+SHIFT];
        mag = sat ? QBOUND[61:0] : rnd[SHIFT+61:SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Magnitudes and sign
            s1_ma_reg  <= a_i[62] ? 63'(-a_i) : 63'(a_i);
            s1_mb_reg  <= b_i[62] ? 63'(-b_i) : 63'(b_i);
            s1_neg_reg <= a_i[62] ^ b_i[62];
            s1_f_reg   <= f_i;
            // Four partial products
            s2_p00_reg <= s1_ma_reg[31:0] * s1_mb_reg[31:0];
            s2_p01_reg <= s1_ma_reg[31:0] * s1_mb_reg[62:32];
            s2_p10_reg <= s1_ma_reg[62:32] * s1_mb_reg[31:0];
            s2_p11_reg <= s1_ma_reg[62:32] * s1_mb_reg[62:32];
            s2_neg_reg <= s1_neg_reg;
            s2_f_reg   <= s1_f_reg;
            // Sum partials
            s3_prod_reg <= (PW'(s2_p11_reg) << 64) + (PW'(s2_p01_reg) << 32)
                         + (PW'(s2_p10_reg) << 32) + PW'(s2_p00_reg);
            s3_neg_reg  <= s2_neg_reg;
            s3_f_reg    <= s2_f_reg;
            // Apply sign
            y_reg.f <= s3_f_reg | sat;
            y_reg.v <= s3_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign y_o = y_reg;
endmodule
`default_nettype wire

// File: sv/lens_distortion_point_map.sv
`default_nettype none
// Five-coefficient Brown-Conrady point mapper. Each item carries one pixel
// coordinate (Q15.8) and returns the distorted coordinate (Q15.8) plus a flag
// that is set when any internal product, sum or the output saturated. The
// datapath is a fixed pipeline: one item is accepted every cycle while
// s_tready is high. Its depth is set by the chain of dependent multiplies,
// each a pipelined unit built from 32x32 partial products. A two-entry
// output stage lets input flow on while one result waits; s_tready drops
// only when both entries are held. The user writes registers through the
// cfg channel while no item is in flight; the block does not enforce this. No startup pass.
module lens_distortion_point_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // src_x [23:0], src_y [47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // dist_x [23:0], dist_y [47:24]
    output logic        m_tuser,   // clipped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ldpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    import ldpm_pkg::*;

    logic [63:0] focal_reg, inv_focal_reg, center_reg, tang_reg;
    logic [31:0] skew_reg, k1_reg, k2_reg, k5_reg;
    q_t          fx, fy, ifx, ify, cx, cy, sk, k1, k2, k3, k4, k5;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  pv;

    fq_t du_reg, dv_reg;
    fq_t ny5, nxa5, nxa9, skny9, ny10, nx10_reg;
    fq_t xx14, yy14, xy14;
    fq_t r2_15_reg, xx2_15_reg, yy2_15_reg, a1_15_reg;
    fq_t a2_16_reg, a3_16_reg, a1_16_reg;
    fq_t r4_19, k1r2_19, r2_19, k3a1_20, k4a2_20, k3a3_20, k4a1_20;
    fq_t cd1_20_reg, cd1_23, tx21_reg, ty21_reg;
    fq_t r6_23, k2r4_23, cd2_24_reg, cd2_27, k5r6_27, cd3_28_reg;
    fq_t nx28, ny28, nxcd32, nycd32, tx32, ty32, xd33_reg, yd33_reg;
    fq_t skyd37, pyf37, xd37, px1_38_reg, py38_reg;
    fq_t pxf42, py42, px43_reg, py43_reg, cx_fq, cy_fq;
    pix_t rx, ry;

    logic        out_valid_reg, skid_full_reg;
    logic [47:0] out_data_reg, skid_data_reg;
    logic        out_flag_reg, skid_flag_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg     <= FOCAL_RESET;
            inv_focal_reg <= INV_FOCAL_RESET;
            center_reg    <= '0;
            skew_reg      <= '0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            tang_reg      <= '0;
            k5_reg        <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FOCAL:      focal_reg     <= cfg_data;
                REG_INV_FOCAL:  inv_focal_reg <= cfg_data;
                REG_CENTER:     center_reg    <= cfg_data;
                REG_SKEW:       skew_reg      <= cfg_data[31:0];
                REG_K1:         k1_reg        <= cfg_data[31:0];
                REG_K2:         k2_reg        <= cfg_data[31:0];
                REG_TANGENTIAL: tang_reg      <= cfg_data;
                REG_K5:         k5_reg        <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign fx  = zext32(focal_reg[63:32]);
    assign fy  = zext32(focal_reg[31:0]);
    assign ifx = zext32(inv_focal_reg[63:32]);
    assign ify = zext32(inv_focal_reg[31:0]);
    assign cx  = sext32(center_reg[63:32]);
    assign cy  = sext32(center_reg[31:0]);
    assign sk  = sext32(skew_reg);
    assign k1  = sext32(k1_reg);
    assign k2  = sext32(k2_reg);
    assign k3  = sext32(tang_reg[63:32]);
    assign k4  = sext32(tang_reg[31:0]);
    assign k5  = sext32(k5_reg);
    assign cx_fq = '{f: 1'b0, v: cx};
    assign cy_fq = '{f: 1'b0, v: cy};

    // Pipeline advances whenever the skid entry is free
    assign en       = !skid_full_reg;
    assign s_tready = en;
    assign pv       = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Single-stage adds and the input offset
    always_ff @(posedge aclk) begin
        if (en) begin
            du_reg.f   <= 1'b0;
            du_reg.v   <= sext32({s_tdata[23:0], 8'b0}) - cx;
            dv_reg.f   <= 1'b0;
            dv_reg.v   <= sext32({s_tdata[47:24], 8'b0}) - cy;
            nx10_reg   <= fq_add(nxa9, fq_neg(skny9));
            r2_15_reg  <= fq_add(xx14, yy14);
            xx2_15_reg <= fq_add(xx14, xx14);
            yy2_15_reg <= fq_add(yy14, yy14);
            a1_15_reg  <= fq_add(xy14, xy14);
            a2_16_reg  <= fq_add(r2_15_reg, xx2_15_reg);
            a3_16_reg  <= fq_add(r2_15_reg, yy2_15_reg);
            a1_16_reg  <= a1_15_reg;
            cd1_20_reg <= fq_add('{f: 1'b0, v: ONE_Q30}, k1r2_19);
            tx21_reg   <= fq_add(k3a1_20, k4a2_20);
            ty21_reg   <= fq_add(k3a3_20, k4a1_20);
            cd2_24_reg <= fq_add(cd1_23, k2r4_23);
            cd3_28_reg <= fq_add(cd2_27, k5r6_27);
            xd33_reg   <= fq_add(nxcd32, tx32);
            yd33_reg   <= fq_add(nycd32, ty32);
            px1_38_reg <= fq_add(xd37, skyd37);
            py38_reg   <= fq_add(pyf37, cy_fq);
            px43_reg   <= fq_add(pxf42, cx_fq);
            py43_reg   <= py42;
        end
    end

    // Normalize
    ldpm_mulq #(.SHIFT(16)) u_ny (.aclk, .en, .a_i(dv_reg.v), .b_i(ify),
                                   .f_i(dv_reg.f), .y_o(ny5));
    ldpm_mulq #(.SHIFT(16)) u_nxa (.aclk, .en, .a_i(du_reg.v), .b_i(ifx),
                                    .f_i(du_reg.f), .y_o(nxa5));
    ldpm_mulq #(.SHIFT(24)) u_skny (.aclk, .en, .a_i(sk), .b_i(ny5.v),
                                     .f_i(ny5.f), .y_o(skny9));
    ldpm_delay #(.DEPTH(MUL_LATENCY)) u_d_nxa (.aclk, .en, .d(nxa5), .q(nxa9));
    ldpm_delay #(.DEPTH(MUL_LATENCY + 1)) u_d_ny (.aclk, .en, .d(ny5), .q(ny10));

    // Squares and cross term
    ldpm_mulq #(.SHIFT(30)) u_xx (.aclk, .en, .a_i(nx10_reg.v), .b_i(nx10_reg.v),
                                   .f_i(nx10_reg.f), .y_o(xx14));
    ldpm_mulq #(.SHIFT(30)) u_yy (.aclk, .en, .a_i(ny10.v), .b_i(ny10.v),
                                   .f_i(ny10.f), .y_o(yy14));
    ldpm_mulq #(.SHIFT(30)) u_xy (.aclk, .en, .a_i(nx10_reg.v), .b_i(ny10.v),
                                   .f_i(nx10_reg.f | ny10.f), .y_o(xy14));

    // Radial powers and factor
    ldpm_mulq #(.SHIFT(30)) u_r4 (.aclk, .en, .a_i(r2_15_reg.v), .b_i(r2_15_reg.v),
                                   .f_i(r2_15_reg.f), .y_o(r4_19));
    ldpm_mulq #(.SHIFT(24)) u_k1r2 (.aclk, .en, .a_i(k1), .b_i(r2_15_reg.v),
                                     .f_i(r2_15_reg.f), .y_o(k1r2_19));
    ldpm_delay #(.DEPTH(MUL_LATENCY)) u_d_r2 (.aclk, .en, .d(r2_15_reg), .q(r2_19));
    ldpm_mulq #(.SHIFT(30)) u_r6 (.aclk, .en, .a_i(r4_19.v), .b_i(r2_19.v),
                                   .f_i(r4_19.f | r2_19.f), .y_o(r6_23));
    ldpm_mulq #(.SHIFT(24)) u_k2r4 (.aclk, .en, .a_i(k2), .b_i(r4_19.v),
                                     .f_i(r4_19.f), .y_o(k2r4_23));
    ldpm_delay #(.DEPTH(3)) u_d_cd1 (.aclk, .en, .d(cd1_20_reg), .q(cd1_23));
    ldpm_mulq #(.SHIFT(24)) u_k5r6 (.aclk, .en, .a_i(k5), .b_i(r6_23.v),
                                     .f_i(r6_23.f), .y_o(k5r6_27));
    ldpm_delay #(.DEPTH(3)) u_d_cd2 (.aclk, .en, .d(cd2_24_reg), .q(cd2_27));

    // Tangential terms
    ldpm_mulq #(.SHIFT(24)) u_k3a1 (.aclk, .en, .a_i(k3), .b_i(a1_16_reg.v),
                                     .f_i(a1_16_reg.f), .y_o(k3a1_20));
    ldpm_mulq #(.SHIFT(24)) u_k4a2 (.aclk, .en, .a_i(k4), .b_i(a2_16_reg.v),
                                     .f_i(a2_16_reg.f), .y_o(k4a2_20));
    ldpm_mulq #(.SHIFT(24)) u_k3a3 (.aclk, .en, .a_i(k3), .b_i(a3_16_reg.v),
                                     .f_i(a3_16_reg.f), .y_o(k3a3_20));
    ldpm_mulq #(.SHIFT(24)) u_k4a1 (.aclk, .en, .a_i(k4), .b_i(a1_16_reg.v),
                                     .f_i(a1_16_reg.f), .y_o(k4a1_20));
    ldpm_delay #(.DEPTH(11)) u_d_tx (.aclk, .en, .d(tx21_reg), .q(tx32));
    ldpm_delay #(.DEPTH(11)) u_d_ty (.aclk, .en, .d(ty21_reg), .q(ty32));

    // Distorted point
    ldpm_delay #(.DEPTH(18)) u_d_nx28 (.aclk, .en, .d(nx10_reg), .q(nx28));
    ldpm_delay #(.DEPTH(18)) u_d_ny28 (.aclk, .en, .d(ny10), .q(ny28));
    ldpm_mulq #(.SHIFT(30)) u_nxcd (.aclk, .en, .a_i(nx28.v), .b_i(cd3_28_reg.v),
                                     .f_i(nx28.f | cd3_28_reg.f), .y_o(nxcd32));
    ldpm_mulq #(.SHIFT(30)) u_nycd (.aclk, .en, .a_i(ny28.v), .b_i(cd3_28_reg.v),
                                     .f_i(ny28.f | cd3_28_reg.f), .y_o(nycd32));

    // Reproject
    ldpm_mulq #(.SHIFT(24)) u_skyd (.aclk, .en, .a_i(sk), .b_i(yd33_reg.v),
                                     .f_i(yd33_reg.f), .y_o(skyd37));
    ldpm_mulq #(.SHIFT(30)) u_pyf (.aclk, .en, .a_i(fy), .b_i(yd33_reg.v),
                                    .f_i(yd33_reg.f), .y_o(pyf37));
    ldpm_delay #(.DEPTH(MUL_LATENCY)) u_d_xd (.aclk, .en, .d(xd33_reg), .q(xd37));
    ldpm_mulq #(.SHIFT(30)) u_pxf (.aclk, .en, .a_i(fx), .b_i(px1_38_reg.v),
                                    .f_i(px1_38_reg.f), .y_o(pxf42));
    ldpm_delay #(.DEPTH(MUL_LATENCY)) u_d_py (.aclk, .en, .d(py38_reg), .q(py42));

    // Round to Q15.8
    assign rx = out_round(px43_reg);
    assign ry = out_round(py43_reg);

    // Output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_tready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (pv) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_flag_reg <= skid_flag_reg;
            end
        end else if (pv) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= {ry.v, rx.v};
                out_flag_reg <= rx.f | ry.f;
            end else begin
                skid_data_reg <= {ry.v, rx.v};
                skid_flag_reg <= rx.f | ry.f;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;
endmodule
`default_nettype wire

// File: sv/ldpm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ldpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);
    // A stalled result holds
    `LDPM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    // Input back-pressure only with a result waiting
    `LDPM_ASSERT(a_stall_pending, !s_tready |-> m_tvalid, "input stalled with no result pending")
    // Back-pressure starts only after an output stall
    `LDPM_ASSERT(a_stall_cause, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "input stalled without output stall")
    // A held skid entry is released once the output is taken
    `LDPM_ASSERT_NEXT(a_skid_drain, !s_tready && m_tready, s_tready, "skid entry not released")
endmodule

bind lens_distortion_point_map ldpm_checker u_ldpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
